// ===== rtl/devtab_pkg.sv =====
// ============================================================================
// Device table package
// Sizes, action and status codes, and the request and result types that the
// device table engine and its top level share.
// ============================================================================
package devtab_pkg;

    // Table geometry and time counter width.
    localparam int ENTRIES   = 64;
    localparam int TIME_BITS = 32;

    // Derived internal widths.
    localparam int IDX_W = $clog2(ENTRIES);
    localparam int CNT_W = $clog2(ENTRIES + 1);

    // Field widths on the ports.
    localparam int ACT_W     = 3;
    localparam int KEY_W     = 32;
    localparam int STATUS_W  = 3;
    localparam int SLOT_W    = 6;
    localparam int COUNT_W   = 7;
    localparam int TIMEOUT_W = 30;
    localparam int M_DATA_W  = 32;
    localparam int M_PAD_W   = M_DATA_W - SLOT_W - 3 * COUNT_W;

    // Age comparison width: holds the age and twice the timeout.
    localparam int CMP_W = (TIME_BITS > TIMEOUT_W + 1) ? TIME_BITS : TIMEOUT_W + 1;

    // One table word: last-seen time above the key.
    localparam int WORD_W = KEY_W + TIME_BITS;

    localparam logic [TIMEOUT_W-1:0] TIMEOUT_RESET = TIMEOUT_W'(30);

    // Action codes.
    localparam logic [ACT_W-1:0] ACT_ADD     = 3'd0;
    localparam logic [ACT_W-1:0] ACT_TOUCH   = 3'd1;
    localparam logic [ACT_W-1:0] ACT_REMOVE  = 3'd2;
    localparam logic [ACT_W-1:0] ACT_CLEANUP = 3'd3;
    localparam logic [ACT_W-1:0] ACT_TICK    = 3'd4;

    // Status codes.
    localparam logic [STATUS_W-1:0] STAT_ADDED     = 3'd0;
    localparam logic [STATUS_W-1:0] STAT_REFRESHED = 3'd1;
    localparam logic [STATUS_W-1:0] STAT_NOT_FOUND = 3'd2;
    localparam logic [STATUS_W-1:0] STAT_REMOVED   = 3'd3;
    localparam logic [STATUS_W-1:0] STAT_FULL      = 3'd4;
    localparam logic [STATUS_W-1:0] STAT_DONE      = 3'd5;

    typedef struct packed {
        logic [ACT_W-1:0] action;
        logic [KEY_W-1:0] dev_ip;
    } devtab_req_t;

    typedef struct packed {
        logic [STATUS_W-1:0] status;
        logic [IDX_W-1:0]    slot;
        logic [CNT_W-1:0]    online_total;
        logic [CNT_W-1:0]    offlined_count;
        logic [CNT_W-1:0]    freed_count;
    } devtab_res_t;

endpackage

// ===== rtl/devtab_ram.sv =====
// ============================================================================
// Generic single-port-write RAM
// One write port and one read port; the read data is registered.
// ============================================================================
module devtab_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write, and registered read.
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

// ===== rtl/devtab_engine.sv =====
// ============================================================================
// Device table engine
// Scans the table memory one slot per cycle for lookups and aging sweeps,
// then writes back the slot of an add or touch. Valid and online flags are flops.
// ============================================================================
module devtab_engine
    import devtab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 start,
    input  devtab_req_t          req,
    input  logic [TIMEOUT_W-1:0] timeout,
    output logic                 idle,
    output logic                 res_valid,
    output devtab_res_t          res,
    input  logic                 res_take
);

    typedef enum logic [3:0] {
        ST_IDLE   = 4'b0001,
        ST_SCAN   = 4'b0010,
        ST_COMMIT = 4'b0100,
        ST_DONE   = 4'b1000
    } state_t;

    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

    state_t                 state_reg, state_next;
    logic [ACT_W-1:0]       act_reg, act_next;
    logic [KEY_W-1:0]       key_reg, key_next;
    logic [TIME_BITS-1:0]   time_reg, time_next;
    logic [ENTRIES-1:0]     valid_reg, valid_next;
    logic [ENTRIES-1:0]     online_reg, online_next;
    logic [CNT_W-1:0]       total_reg, total_next;
    logic [IDX_W-1:0]       iss_idx_reg, iss_idx_next;
    logic                   iss_on_reg, iss_on_next;
    logic                   a_on_reg, a_on_next;
    logic [IDX_W-1:0]       a_idx_reg, a_idx_next;
    logic                   b_on_reg, b_on_next;
    logic [IDX_W-1:0]       b_idx_reg, b_idx_next;
    logic [TIME_BITS-1:0]   b_age_reg, b_age_next;
    logic                   hit_reg, hit_next;
    logic [IDX_W-1:0]       hit_idx_reg, hit_idx_next;
    logic                   free_reg, free_next;
    logic [IDX_W-1:0]       free_idx_reg, free_idx_next;
    logic [CNT_W-1:0]       offl_reg, offl_next;
    logic [CNT_W-1:0]       rem_reg, rem_next;
    devtab_res_t            res_reg, res_next;

    logic                   rd_en;
    logic [WORD_W-1:0]      rd_data;
    logic [KEY_W-1:0]       rd_key;
    logic [TIME_BITS-1:0]   rd_seen;
    logic                   wr_en;
    logic [IDX_W-1:0]       wr_addr;
    logic [TIME_BITS-1:0]   age_a;
    logic [CMP_W-1:0]       age_b;
    logic [CMP_W-1:0]       limit;
    logic [CMP_W-1:0]       limit2;
    logic                   key_match;

    // Table memory: key in the low half, last-seen time in the high half.
    devtab_ram #(
        .WIDTH (WORD_W),
        .DEPTH (ENTRIES)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (wr_addr),
        .wr_data ({time_reg, key_reg}),
        .rd_en   (rd_en),
        .rd_addr (iss_idx_reg),
        .rd_data (rd_data)
    );

    assign rd_key  = rd_data[KEY_W-1:0];
    assign rd_seen = rd_data[WORD_W-1:KEY_W];
    assign rd_en   = (state_reg == ST_SCAN) && iss_on_reg;

    // Age of the slot whose word just came back, and the sweep limits.
    assign age_a     = time_reg - rd_seen;
    assign age_b     = CMP_W'(b_age_reg);
    assign limit     = CMP_W'(timeout);
    assign limit2    = limit << 1;
    assign key_match = valid_reg[a_idx_reg] && (rd_key == key_reg);

    assign idle      = (state_reg == ST_IDLE);
    assign res_valid = (state_reg == ST_DONE);
    assign res       = res_reg;

    // Sequencer and datapath.
    always_comb begin
        state_next    = state_reg;
        act_next      = act_reg;
        key_next      = key_reg;
        time_next     = time_reg;
        valid_next    = valid_reg;
        online_next   = online_reg;
        total_next    = total_reg;
        iss_idx_next  = iss_idx_reg;
        iss_on_next   = iss_on_reg;
        a_on_next     = 1'b0;
        a_idx_next    = a_idx_reg;
        b_on_next     = 1'b0;
        b_idx_next    = b_idx_reg;
        b_age_next    = b_age_reg;
        hit_next      = hit_reg;
        hit_idx_next  = hit_idx_reg;
        free_next     = free_reg;
        free_idx_next = free_idx_reg;
        offl_next     = offl_reg;
        rem_next      = rem_reg;
        res_next      = res_reg;
        wr_en         = 1'b0;
        wr_addr       = hit_reg ? hit_idx_reg : free_idx_reg;

        unique case (state_reg)
            ST_IDLE: begin
                if (start) begin
                    act_next     = req.action;
                    key_next     = req.dev_ip;
                    hit_next     = 1'b0;
                    free_next    = 1'b0;
                    offl_next    = '0;
                    rem_next     = '0;
                    iss_idx_next = '0;
                    res_next     = '{status: STAT_DONE, slot: '0, online_total: total_reg,
                                     offlined_count: '0, freed_count: '0};
                    if (req.action == ACT_ADD || req.action == ACT_TOUCH ||
                        req.action == ACT_REMOVE || req.action == ACT_CLEANUP) begin
                        iss_on_next = 1'b1;
                        state_next  = ST_SCAN;
                    end else begin
                        // A tick bumps the clock; unknown actions change nothing.
                        if (req.action == ACT_TICK) begin
                            time_next = time_reg + TIME_BITS'(1);
                        end
                        state_next = ST_DONE;
                    end
                end
            end

            ST_SCAN: begin
                // Issue one read per cycle until the last slot or a lookup hit.
                if (iss_on_reg) begin
                    iss_idx_next = iss_idx_reg + IDX_W'(1);
                    if (iss_idx_reg == LAST_IDX) begin
                        iss_on_next = 1'b0;
                    end
                end
                a_on_next  = iss_on_reg;
                a_idx_next = iss_idx_reg;

                if (act_reg == ACT_CLEANUP) begin
                    // Stage one registers the age, stage two ages the slot.
                    b_on_next  = a_on_reg;
                    b_idx_next = a_idx_reg;
                    b_age_next = age_a;
                    if (b_on_reg && valid_reg[b_idx_reg] && (age_b > limit)) begin
                        if (online_reg[b_idx_reg]) begin
                            online_next[b_idx_reg] = 1'b0;
                            total_next             = total_reg - CNT_W'(1);
                            offl_next              = offl_reg + CNT_W'(1);
                        end
                        if (age_b > limit2) begin
                            valid_next[b_idx_reg] = 1'b0;
                            rem_next              = rem_reg + CNT_W'(1);
                        end
                    end
                    if (b_on_reg && (b_idx_reg == LAST_IDX)) begin
                        res_next   = '{status: STAT_DONE, slot: '0, online_total: total_next,
                                       offlined_count: offl_next, freed_count: rem_next};
                        state_next = ST_DONE;
                    end
                end else if (a_on_reg) begin
                    // Lookup: first matching slot wins, lowest free slot is kept.
                    if (key_match) begin
                        hit_next     = 1'b1;
                        hit_idx_next = a_idx_reg;
                        iss_on_next  = 1'b0;
                        state_next   = ST_COMMIT;
                    end else begin
                        if (!valid_reg[a_idx_reg] && !free_reg) begin
                            free_next     = 1'b1;
                            free_idx_next = a_idx_reg;
                        end
                        if (a_idx_reg == LAST_IDX) begin
                            iss_on_next = 1'b0;
                            state_next  = ST_COMMIT;
                        end
                    end
                end
            end

            ST_COMMIT: begin
                res_next.status = STAT_NOT_FOUND;
                res_next.slot   = '0;
                unique case (act_reg)
                    ACT_ADD, ACT_TOUCH: begin
                        if (hit_reg) begin
                            // Refresh an existing entry.
                            wr_en           = 1'b1;
                            res_next.status = STAT_REFRESHED;
                            res_next.slot   = hit_idx_reg;
                            if (!online_reg[hit_idx_reg]) begin
                                online_next[hit_idx_reg] = 1'b1;
                                total_next               = total_reg + CNT_W'(1);
                            end
                        end else if (act_reg == ACT_ADD && free_reg) begin
                            // New entry in the lowest free slot.
                            wr_en                     = 1'b1;
                            valid_next[free_idx_reg]  = 1'b1;
                            online_next[free_idx_reg] = 1'b1;
                            total_next                = total_reg + CNT_W'(1);
                            res_next.status           = STAT_ADDED;
                            res_next.slot             = free_idx_reg;
                        end else if (act_reg == ACT_ADD) begin
                            res_next.status = STAT_FULL;
                        end
                    end
                    ACT_REMOVE: begin
                        if (hit_reg) begin
                            valid_next[hit_idx_reg]  = 1'b0;
                            online_next[hit_idx_reg] = 1'b0;
                            if (online_reg[hit_idx_reg]) begin
                                total_next = total_reg - CNT_W'(1);
                            end
                            res_next.status = STAT_REMOVED;
                            res_next.slot   = hit_idx_reg;
                        end
                    end
                    default: begin
                        res_next.status = STAT_DONE;
                    end
                endcase
                res_next.online_total = total_next;
                state_next            = ST_DONE;
            end

            ST_DONE: begin
                if (res_take) begin
                    state_next = ST_IDLE;
                end
            end

            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg  <= ST_IDLE;
            time_reg   <= '0;
            valid_reg  <= '0;
            online_reg <= '0;
            total_reg  <= '0;
            iss_on_reg <= 1'b0;
            a_on_reg   <= 1'b0;
            b_on_reg   <= 1'b0;
        end else begin
            state_reg  <= state_next;
            time_reg   <= time_next;
            valid_reg  <= valid_next;
            online_reg <= online_next;
            total_reg  <= total_next;
            iss_on_reg <= iss_on_next;
            a_on_reg   <= a_on_next;
            b_on_reg   <= b_on_next;
        end
    end

    // Working registers of the current item.
    always_ff @(posedge aclk) begin
        act_reg      <= act_next;
        key_reg      <= key_next;
        iss_idx_reg  <= iss_idx_next;
        a_idx_reg    <= a_idx_next;
        b_idx_reg    <= b_idx_next;
        b_age_reg    <= b_age_next;
        hit_reg      <= hit_next;
        hit_idx_reg  <= hit_idx_next;
        free_reg     <= free_next;
        free_idx_reg <= free_idx_next;
        offl_reg     <= offl_next;
        rem_reg      <= rem_next;
        res_reg      <= res_next;
    end

endmodule

// ===== rtl/device_table_with_aging.sv =====
// ============================================================================
// Device table with aging
// Learning table of devices keyed by IPv4 address, with a tick-driven clock
// and an aging sweep, behind stream input and output channels.
// ============================================================================
// A tick or an unknown action goes straight to its result; add, touch and remove
// scan until the slot that hits or the last slot; cleanup sweeps every slot.
// The block works on one item at a time, scanning memory one slot per cycle.
// The next item is taken the cycle after the result moves into the output register.
// Reset clears valid and online flags, the clock and the online count, and
// loads the timeout with 30; the table memory needs no clearing pass.
module device_table_with_aging
    import devtab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    // Configuration: timeout_ticks.
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] cfg_data,
    // Input stream.
    input  logic                 s_tvalid,
    output logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // dev_ip[31:0]
    input  logic [ACT_W-1:0]     s_tuser,   // action[2:0]
    // Result stream.
    output logic                 m_tvalid,
    input  logic                 m_tready,
    output logic [M_DATA_W-1:0]  m_tdata,   // slot[5:0], online_total[12:6],
                                            // offlined_count[19:13],
                                            // freed_count[26:20], zero[31:27]
    output logic [STATUS_W-1:0]  m_tuser    // status[2:0]
);

    logic [TIMEOUT_W-1:0] timeout_reg;
    logic                 m_tvalid_reg, m_tvalid_next;
    logic [M_DATA_W-1:0]  m_tdata_reg;
    logic [STATUS_W-1:0]  m_tuser_reg;
    logic                 eng_idle;
    logic                 eng_res_valid;
    devtab_res_t          eng_res;
    logic                 res_take;
    devtab_req_t          req;

    // Timeout register; writes are always taken.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            timeout_reg <= TIMEOUT_RESET;
        end else if (cfg_valid) begin
            timeout_reg <= cfg_data;
        end
    end

    assign s_tready = eng_idle;
    assign req      = '{action: s_tuser, dev_ip: s_tdata};

    devtab_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (s_tvalid && eng_idle),
        .req       (req),
        .timeout   (timeout_reg),
        .idle      (eng_idle),
        .res_valid (eng_res_valid),
        .res       (eng_res),
        .res_take  (res_take)
    );

    // Output register: a finished result moves in when the slot is free.
    assign res_take = eng_res_valid && (!m_tvalid_reg || m_tready);

    always_comb begin
        m_tvalid_next = m_tvalid_reg;
        if (res_take) begin
            m_tvalid_next = 1'b1;
        end else if (m_tready) begin
            m_tvalid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else begin
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_take) begin
            m_tuser_reg <= eng_res.status;
            m_tdata_reg <= {{M_PAD_W{1'b0}},
                            COUNT_W'(eng_res.freed_count),
                            COUNT_W'(eng_res.offlined_count),
                            COUNT_W'(eng_res.online_total),
                            SLOT_W'(eng_res.slot)};
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;
    assign m_tuser  = m_tuser_reg;

endmodule

// ===== rtl/devtab_checker.sv =====
// ============================================================================
// Device table port checker
// Watches the top-level ports and checks result beats over time.
// ============================================================================
module devtab_port_checker
    import devtab_pkg::*;
(
    input logic                 aclk,
    input logic                 aresetn,
    input logic                 m_tvalid,
    input logic                 m_tready,
    input logic [M_DATA_W-1:0]  m_tdata,
    input logic [STATUS_W-1:0]  m_tuser
);

    // A stalled result beat holds.
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result beat changed while stalled");

    // Reset leaves no result pending.
    a_reset: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // Misses, a full table, sweeps and ticks name no slot.
    a_slot_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (m_tuser == STAT_NOT_FOUND || m_tuser == STAT_FULL ||
                     m_tuser == STAT_DONE) |-> m_tdata[5:0] == '0)
        else $error("slot set on a result without an entry");

    // Sweep counters are only reported on a result with the done status.
    a_counts_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != STAT_DONE |-> m_tdata[26:13] == '0)
        else $error("sweep counts set on a lookup result");

    // Status codes stay within the defined set, and padding stays zero.
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tuser <= STAT_DONE && m_tdata[31:27] == '0)
        else $error("bad status code or padding");

endmodule

bind device_table_with_aging devtab_port_checker u_devtab_checker (.*);

// ===== test/devtab_checker.sv =====
// ----------------------------------------------------------------------------
// Device table checker
// Watches the timeout register, request and result channels of the device
// table, keeps a shadow copy of the table, the clock and the online count,
// predicts the result of every accepted request and compares each result
// beat field by field against the oldest prediction.
// ----------------------------------------------------------------------------
module devtab_checker
    import devtab_pkg::*;
(
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 cfg_valid,
    input  logic                 cfg_ready,
    input  logic [TIMEOUT_W-1:0] cfg_data,
    input  logic                 s_tvalid,
    input  logic                 s_tready,
    input  logic [KEY_W-1:0]     s_tdata,   // dev_ip[31:0]
    input  logic [ACT_W-1:0]     s_tuser,   // action[2:0]
    input  logic                 m_tvalid,
    input  logic                 m_tready,
    input  logic [M_DATA_W-1:0]  m_tdata,   // slot, online, offlined, removed, zero
    input  logic [STATUS_W-1:0]  m_tuser,   // status[2:0]
    output int unsigned          errors,
    output int unsigned          results_seen,
    output int unsigned          waiting
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct {
        logic [STATUS_W-1:0] status;
        logic [SLOT_W-1:0]   slot;
        logic [COUNT_W-1:0]  online_total;
        logic [COUNT_W-1:0]  offlined_count;
        logic [COUNT_W-1:0]  freed_count;
    } table_result_t;

    // Shadow copy of the device table and its timekeeping.
    logic [TIMEOUT_W-1:0] timeout_ticks;
    logic                 entry_used [ENTRIES];
    logic [KEY_W-1:0]     entry_ip   [ENTRIES];
    logic [TIME_BITS-1:0] entry_seen [ENTRIES];
    logic                 entry_up   [ENTRIES];
    logic [TIME_BITS-1:0] clock_now;
    int                   online_now;

    table_result_t expected_results[$];

    // First used slot holding this address, or -1.
    function automatic int lookup_ip(input logic [KEY_W-1:0] ip);
        for (int i = 0; i < ENTRIES; i++) begin
            if (entry_used[i] && entry_ip[i] == ip) return i;
        end
        return -1;
    endfunction

    // Lowest free slot, or -1 when the table is full.
    function automatic int lowest_free();
        for (int i = 0; i < ENTRIES; i++) begin
            if (!entry_used[i]) return i;
        end
        return -1;
    endfunction

    function automatic void mark_seen(input int s);
        entry_seen[s] = clock_now;
        if (!entry_up[s]) begin
            entry_up[s] = 1'b1;
            online_now++;
        end
    endfunction

    function automatic void take_offline(input int s);
        if (entry_up[s]) begin
            entry_up[s] = 1'b0;
            online_now--;
        end
    endfunction

    // Applies one request to the shadow table and returns the result it gives.
    function automatic table_result_t predict_table_step(input logic [ACT_W-1:0] action,
                                                         input logic [KEY_W-1:0] ip);
        table_result_t        r;
        int                   s;
        int                   offlined;
        int                   freed;
        logic [TIME_BITS-1:0] age;
        longint unsigned      lim;

        r.status = STAT_DONE;
        r.slot   = '0;
        offlined = 0;
        freed    = 0;
        lim      = longint'(timeout_ticks);
        case (action)
            ACT_ADD: begin
                s = lookup_ip(ip);
                if (s >= 0) begin
                    mark_seen(s);
                    r.status = STAT_REFRESHED;
                    r.slot   = SLOT_W'(s);
                end else begin
                    s = lowest_free();
                    if (s < 0) begin
                        r.status = STAT_FULL;
                    end else begin
                        entry_used[s] = 1'b1;
                        entry_ip[s]   = ip;
                        entry_up[s]   = 1'b0;
                        mark_seen(s);
                        r.status = STAT_ADDED;
                        r.slot   = SLOT_W'(s);
                    end
                end
            end
            ACT_TOUCH: begin
                s = lookup_ip(ip);
                if (s >= 0) begin
                    mark_seen(s);
                    r.status = STAT_REFRESHED;
                    r.slot   = SLOT_W'(s);
                end else begin
                    r.status = STAT_NOT_FOUND;
                end
            end
            ACT_REMOVE: begin
                s = lookup_ip(ip);
                if (s >= 0) begin
                    take_offline(s);
                    entry_used[s] = 1'b0;
                    r.status = STAT_REMOVED;
                    r.slot   = SLOT_W'(s);
                end else begin
                    r.status = STAT_NOT_FOUND;
                end
            end
            ACT_CLEANUP: begin
                // Age wraps with the clock; an entry freed in this sweep is
                // still counted as offlined if it was online.
                for (int i = 0; i < ENTRIES; i++) begin
                    if (entry_used[i]) begin
                        age = clock_now - entry_seen[i];
                        if (64'(age) > lim) begin
                            if (entry_up[i]) begin
                                take_offline(i);
                                offlined++;
                            end
                            if (64'(age) > 2 * lim) begin
                                entry_used[i] = 1'b0;
                                freed++;
                            end
                        end
                    end
                end
            end
            ACT_TICK: begin
                clock_now = clock_now + 1'b1;
            end
            default: begin
            end
        endcase
        r.online_total   = COUNT_W'(online_now);
        r.offlined_count = COUNT_W'(offlined);
        r.freed_count    = COUNT_W'(freed);
        return r;
    endfunction

    function automatic void compare_field(input string name, input int unsigned want,
                                          input int unsigned got);
        if (want != got) begin
            errors++;
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
        end
    endfunction

    // Sample all three channels at the clock edge.
    always @(posedge aclk) begin
        table_result_t want;

        if (!aresetn) begin
            timeout_ticks = TIMEOUT_RESET;
            for (int i = 0; i < ENTRIES; i++) begin
                entry_used[i] = 1'b0;
                entry_ip[i]   = '0;
                entry_seen[i] = '0;
                entry_up[i]   = 1'b0;
            end
            clock_now    = '0;
            online_now   = 0;
            errors       = 0;
            results_seen = 0;
            expected_results.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                timeout_ticks = cfg_data;
            end
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    errors++;
                    $display("%0t: result beat with nothing expected, status %0d data %h",
                             $time, m_tuser, m_tdata);
                end else begin
                    want = expected_results.pop_front();
                    compare_field("status", want.status, m_tuser);
                    compare_field("slot", want.slot, m_tdata[SLOT_W-1:0]);
                    compare_field("online_total", want.online_total,
                                  m_tdata[SLOT_W +: COUNT_W]);
                    compare_field("offlined_count", want.offlined_count,
                                  m_tdata[SLOT_W + COUNT_W +: COUNT_W]);
                    compare_field("freed_count", want.freed_count,
                                  m_tdata[SLOT_W + 2 * COUNT_W +: COUNT_W]);
                    compare_field("padding", 0, m_tdata[M_DATA_W-1 -: M_PAD_W]);
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(predict_table_step(s_tuser, s_tdata));
            end
        end
        waiting = expected_results.size();
    end

endmodule

// ===== test/tb_top.sv =====
// ----------------------------------------------------------------------------
// Device table testbench
// Drives add, touch, remove, tick, cleanup and unknown requests into the device
// table under several timeout settings, with random gaps on both channels, one
// long result back-pressure stretch and a no-gap phase. The checker predicts
// and compares every result; this module gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    import devtab_pkg::*;

    localparam int LONG_HOLD = 300;
    localparam int POOL_MAX  = 96;

    logic                 aclk      = 1'b0;
    logic                 aresetn   = 1'b0;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [TIMEOUT_W-1:0] cfg_data  = '0;
    logic                 s_tvalid  = 1'b0;
    logic                 s_tready;
    logic [KEY_W-1:0]     s_tdata   = '0;
    logic [ACT_W-1:0]     s_tuser   = ACT_TICK;
    logic                 m_tvalid;
    logic                 m_tready  = 1'b0;
    logic [M_DATA_W-1:0]  m_tdata;
    logic [STATUS_W-1:0]  m_tuser;

    int unsigned errors;
    int unsigned results_seen;
    int unsigned waiting;
    int unsigned sent_count   = 0;
    bit          quiet        = 1'b0;
    bit          hold_request = 1'b0;

    logic [KEY_W-1:0] key_pool [POOL_MAX];

    always begin
        #5 aclk = 1'b1;
        #5 aclk = 1'b0;
    end

    device_table_with_aging i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser)
    );

    devtab_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_data     (cfg_data),
        .s_tvalid     (s_tvalid),
        .s_tready     (s_tready),
        .s_tdata      (s_tdata),
        .s_tuser      (s_tuser),
        .m_tvalid     (m_tvalid),
        .m_tready     (m_tready),
        .m_tdata      (m_tdata),
        .m_tuser      (m_tuser),
        .errors       (errors),
        .results_seen (results_seen),
        .waiting      (waiting)
    );

    // Offers one request beat after a random gap and waits until it is taken.
    task automatic send_request(input logic [ACT_W-1:0] act, input logic [KEY_W-1:0] ip);
        int gap;
        gap = quiet ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= act;
        s_tdata  <= ip;
        do @(posedge aclk); while (!s_tready);
        sent_count++;
    endtask

    // Writes the timeout once every outstanding result has been taken.
    task automatic set_timeout(input logic [TIMEOUT_W-1:0] value);
        s_tvalid <= 1'b0;
        while (results_seen != sent_count) @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
    endtask

    // One random phase: requests on a pool of addresses, plus some noise.
    task automatic run_phase(input logic [TIMEOUT_W-1:0] timeout, input int pool_n,
                             input int items, input int add_share, input bit pressure);
        logic [KEY_W-1:0] k;
        int               r;

        set_timeout(timeout);
        for (int i = 0; i < pool_n; i++) key_pool[i] = $urandom();
        for (int n = 0; n < items; n++) begin
            if (pressure && n == items / 4) hold_request = 1'b1;
            k = key_pool[$urandom_range(0, pool_n - 1)];
            if ($urandom_range(0, 99) < add_share) begin
                send_request(ACT_ADD, k);
            end else begin
                r = $urandom_range(0, 99);
                if (r < 15) send_request(ACT_TOUCH, k);
                else if (r < 30) send_request(ACT_REMOVE, k);
                else if (r < 60) send_request(ACT_TICK, $urandom());
                else if (r < 88) send_request(ACT_CLEANUP, $urandom());
                else if (r < 92) send_request(ACT_REMOVE, $urandom());
                else if (r < 96) send_request(ACT_TOUCH, $urandom());
                else send_request(ACT_W'($urandom_range(ACT_TICK + 1, (1 << ACT_W) - 1)),
                                  $urandom());
            end
        end
    endtask

    // Result side: random stalls per beat, and one long hold when asked.
    initial begin
        int gap;
        wait (aresetn);
        forever begin
            if (hold_request) begin
                hold_request = 1'b0;
                m_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge aclk);
            end
            gap = quiet ? 0 : $urandom_range(0, 5);
            if (gap > 0) begin
                m_tready <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
            m_tready <= 1'b1;
            do @(posedge aclk); while (!m_tvalid);
        end
    end

    initial begin
        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: key extremes, hit, refresh, miss, lowest free slot reuse.
        send_request(ACT_TICK, '0);
        send_request(ACT_ADD, '0);
        send_request(ACT_ADD, '1);
        send_request(ACT_ADD, '0);
        send_request(ACT_TOUCH, '1);
        send_request(ACT_TOUCH, 32'h1234_5678);
        send_request(ACT_REMOVE, 32'h1234_5678);
        send_request(ACT_REMOVE, '0);
        send_request(ACT_ADD, 32'hC0A8_0001);
        send_request(ACT_CLEANUP, '1);
        for (int a = ACT_TICK + 1; a < (1 << ACT_W); a++) begin
            send_request(ACT_W'(a), 32'hA5A5_5A5A);
        end

        // Timeout of one: entries go offline first, then are freed.
        set_timeout(TIMEOUT_W'(1));
        send_request(ACT_TICK, '0);
        send_request(ACT_TICK, '0);
        send_request(ACT_CLEANUP, '0);
        send_request(ACT_TICK, '0);
        send_request(ACT_CLEANUP, '0);

        // Zero timeout: any nonzero age takes the entry offline and frees it.
        set_timeout('0);
        send_request(ACT_ADD, 32'h0A00_0001);
        send_request(ACT_CLEANUP, '0);
        send_request(ACT_TICK, '0);
        send_request(ACT_CLEANUP, '0);

        // Random phases over several timeouts, pool sizes and add shares.
        run_phase(TIMEOUT_W'(1), 12, 200, 35, 1'b0);
        run_phase('0, 12, 120, 35, 1'b0);
        run_phase('1, 90, 250, 70, 1'b0);
        run_phase(TIMEOUT_W'(5), 24, 250, 35, 1'b1);
        quiet = 1'b1;
        run_phase(TIMEOUT_W'(2), 10, 200, 35, 1'b0);
        quiet = 1'b0;
        run_phase(TIMEOUT_RESET, 40, 250, 40, 1'b0);
        run_phase(TIMEOUT_W'(7), 70, 400, 65, 1'b0);

        // Drain, then leave room for any stray result beat.
        s_tvalid <= 1'b0;
        while (results_seen != sent_count) @(posedge aclk);
        repeat (ENTRIES + 8) @(posedge aclk);
        if (waiting != 0) begin
            $display("%0t: %0d expected results never arrived", $time, waiting);
        end
        if (errors == 0 && waiting == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog, several times the slowest legal run.
    initial begin
        #8_000_000;
        $display("Some tests failed");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/devtab_pkg.sv
rtl/devtab_ram.sv
rtl/devtab_engine.sv
rtl/device_table_with_aging.sv
rtl/devtab_checker.sv
test/devtab_checker.sv
test/tb_top.sv
